// ===== design/rau_pkg.sv =====
package rau_pkg;

  localparam int unsigned FieldW = 32;

  typedef enum logic [1:0] {
    KIND_ADD = 2'd0,
    KIND_SUB = 2'd1,
    KIND_MUL = 2'd2,
    KIND_DIV = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CLASS_FINITE = 2'd0,
    CLASS_INF    = 2'd1,
    CLASS_NAN    = 2'd2
  } class_e;

  // Sign and magnitude of one operand field; only the low WIDTH bits of mag are used.
  typedef struct packed {
    logic              neg;
    logic [FieldW-1:0] mag;
  } sm_t;

  typedef struct packed {
    kind_e kind;
    sm_t   a_num;
    sm_t   a_den;
    sm_t   b_num;
    sm_t   b_den;
  } op_t;

  typedef struct packed {
    logic [FieldW-1:0] num;
    logic [FieldW-1:0] den;
    class_e            cls;
  } res_t;

endpackage

// ===== design/rational_arith_unit.sv =====
// Fraction arithmetic with gcd reduction: add, subtract, multiply or divide two
// fractions num/den, where a zero denominator marks a non-finite operand.
// Input channel: drive kind_i and the four operand ports with push high; a beat
// is taken on a clock edge where push is high and full is low. A two-entry
// queue in the front end holds beats while the back end is busy.
// Result channel: while empty is low, res_num_o, res_den_o and res_class_o show
// the oldest result; it is taken on an edge where pop is high. A stalled result
// waits in the output register and the back end then holds its next result.
// Processing: the first operand, the second operand and the result are each reduced
// by a binary gcd of its two inputs followed by a divide; a zero numerator or a
// non-finite value skips that reduction. The gcd and divide unit of the back end
// is shared, and one beat is worked on at a time.
// Reset clears the queue, the sequencer and the output register; nothing else
// needs clearing.
module rational_arith_unit #(
  parameter int unsigned WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  kind_i,
  input  logic [31:0] a_num_i,
  input  logic [31:0] a_den_i,
  input  logic [31:0] b_num_i,
  input  logic [31:0] b_den_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] res_num_o,
  output logic [31:0] res_den_o,
  output logic [1:0]  res_class_o
);

  logic          op_valid, op_ready;
  rau_pkg::op_t  op;
  logic          res_valid, res_ready;
  rau_pkg::res_t res;
  logic          out_valid_q;
  rau_pkg::res_t out_q;

  rau_front #(
    .WIDTH(WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .kind_i     (kind_i),
    .a_num_i    (a_num_i),
    .a_den_i    (a_den_i),
    .b_num_i    (b_num_i),
    .b_den_i    (b_den_i),
    .op_valid_o (op_valid),
    .op_ready_i (op_ready),
    .op_o       (op)
  );

  rau_back #(
    .WIDTH(WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (op_valid),
    .op_ready_o  (op_ready),
    .op_i        (op),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !out_valid_q || pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign empty       = !out_valid_q;
  assign res_num_o   = out_q.num;
  assign res_den_o   = out_q.den;
  assign res_class_o = out_q.cls;

endmodule

// ===== design/rau_front.sv =====
module rau_front #(
  parameter int unsigned WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic [1:0]                   kind_i,
  input  logic [rau_pkg::FieldW-1:0]   a_num_i,
  input  logic [rau_pkg::FieldW-1:0]   a_den_i,
  input  logic [rau_pkg::FieldW-1:0]   b_num_i,
  input  logic [rau_pkg::FieldW-1:0]   b_den_i,
  output logic                         op_valid_o,
  input  logic                         op_ready_i,
  output rau_pkg::op_t                 op_o
);

  localparam int unsigned Depth = 2;

  rau_pkg::op_t mem_q [Depth];
  logic         wr_ptr_q, rd_ptr_q;
  logic [1:0]   cnt_q;
  logic         wr_en, rd_en;
  rau_pkg::op_t op_in;

  // Operands are sign-extended from bit WIDTH-1 and split into sign and magnitude.
  function automatic rau_pkg::sm_t to_sm(input logic [rau_pkg::FieldW-1:0] raw);
    logic [WIDTH-1:0] low;
    logic [WIDTH-1:0] neg_low;
    rau_pkg::sm_t     r;
    low     = raw[WIDTH-1:0];
    neg_low = ~low + 1'b1;
    r.neg   = low[WIDTH-1];
    r.mag   = rau_pkg::FieldW'(low[WIDTH-1] ? neg_low : low);
    return r;
  endfunction

  always_comb begin
    op_in.kind  = rau_pkg::kind_e'(kind_i);
    op_in.a_num = to_sm(a_num_i);
    op_in.a_den = to_sm(a_den_i);
    op_in.b_num = to_sm(b_num_i);
    op_in.b_den = to_sm(b_den_i);
  end

  assign full       = (cnt_q == 2'(Depth));
  assign op_valid_o = (cnt_q != 2'd0);
  assign op_o       = mem_q[rd_ptr_q];
  assign wr_en      = push && !full;
  assign rd_en      = op_valid_o && op_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= op_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (rd_en) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (wr_en && !rd_en) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (rd_en && !wr_en) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

// ===== design/rau_back.sv =====
module rau_back #(
  parameter int unsigned WIDTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          op_valid_i,
  output logic          op_ready_o,
  input  rau_pkg::op_t  op_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output rau_pkg::res_t res_o
);

  localparam int unsigned DW   = 2 * WIDTH;
  localparam int unsigned CntW = $clog2(DW);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RED  = 4'd1;
  localparam logic [3:0] ST_GCD  = 4'd2;
  localparam logic [3:0] ST_DIV  = 4'd3;
  localparam logic [3:0] ST_WB   = 4'd4;
  localparam logic [3:0] ST_M0   = 4'd5;
  localparam logic [3:0] ST_M1   = 4'd6;
  localparam logic [3:0] ST_M2   = 4'd7;
  localparam logic [3:0] ST_M3   = 4'd8;
  localparam logic [3:0] ST_OUT  = 4'd9;

  localparam logic [1:0] SEL_A = 2'd0;
  localparam logic [1:0] SEL_B = 2'd1;
  localparam logic [1:0] SEL_R = 2'd2;

  typedef struct packed {
    logic             neg;
    logic [WIDTH-1:0] mag;
  } nsm_t;

  typedef struct packed {
    logic          neg;
    logic [DW-1:0] mag;
  } wsm_t;

  logic [3:0]     state_q, state_d;
  logic [1:0]     sel_q;
  rau_pkg::kind_e kind_q;
  nsm_t           an_q, ad_q, bn_q, bd_q;
  wsm_t           t_q, prod_q, n_q, d_q;
  logic [DW-1:0]  u_q, v_q, g_q, rx_q, qx_q, ry_q, qy_q;
  logic [CntW-1:0] k_q, cnt_q;

  logic           finite_ops, is_addsub, is_sub, nan_op;
  nsm_t           mul_a, mul_b;
  wsm_t           prod_d, n_fin, n_inf;
  logic [DW-1:0]  red_x, red_y;
  logic           red_skip;
  logic [DW:0]    rx_sh, ry_sh;
  logic           x_ge, y_ge;

  function automatic wsm_t widen(input nsm_t x);
    wsm_t r;
    r.neg = x.neg;
    r.mag = DW'(x.mag);
    return r;
  endfunction

  function automatic wsm_t neg_if(input wsm_t x, input logic flip);
    wsm_t r;
    r     = x;
    r.neg = x.neg ^ (flip && (x.mag != '0));
    return r;
  endfunction

  function automatic wsm_t add_sm(input wsm_t x, input wsm_t y);
    wsm_t r;
    if (x.neg == y.neg) begin
      r.neg = x.neg;
      r.mag = x.mag + y.mag;
    end else if (x.mag >= y.mag) begin
      r.neg = x.neg;
      r.mag = x.mag - y.mag;
    end else begin
      r.neg = y.neg;
      r.mag = y.mag - x.mag;
    end
    if (r.mag == '0) begin
      r.neg = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [rau_pkg::FieldW-1:0] trunc_out(input wsm_t x);
    logic [DW-1:0]    tc;
    logic [WIDTH-1:0] lo;
    tc = x.neg ? (~x.mag + 1'b1) : x.mag;
    lo = tc[WIDTH-1:0];
    return rau_pkg::FieldW'($signed(lo));
  endfunction

  assign finite_ops = (ad_q.mag != '0) && (bd_q.mag != '0);
  assign is_addsub  = (kind_q == rau_pkg::KIND_ADD) || (kind_q == rau_pkg::KIND_SUB);
  assign is_sub     = (kind_q == rau_pkg::KIND_SUB);
  assign nan_op     = ((an_q.mag == '0) && (ad_q.mag == '0)) ||
                      ((bn_q.mag == '0) && (bd_q.mag == '0));

  // One shared multiplier; its product is always registered before use.
  always_comb begin
    unique case (state_q)
      ST_M1: begin
        mul_a = bn_q;
        mul_b = ad_q;
      end
      ST_M2: begin
        mul_a = ad_q;
        mul_b = (kind_q == rau_pkg::KIND_DIV) ? bn_q : bd_q;
      end
      default: begin
        mul_a = an_q;
        mul_b = (kind_q == rau_pkg::KIND_MUL) ? bn_q : bd_q;
      end
    endcase
    prod_d.mag = DW'(mul_a.mag) * DW'(mul_b.mag);
    prod_d.neg = (mul_a.neg ^ mul_b.neg) && (prod_d.mag != '0);
  end

  always_comb begin
    n_fin = is_addsub ? add_sm(t_q, neg_if(prod_q, is_sub)) : t_q;
    if (is_addsub) begin
      n_inf = nan_op ? '0 : add_sm(widen(an_q), neg_if(widen(bn_q), is_sub));
    end else begin
      n_inf = t_q;
    end
  end

  always_comb begin
    unique case (sel_q)
      SEL_A: begin
        red_x    = DW'(an_q.mag);
        red_y    = DW'(ad_q.mag);
        red_skip = (ad_q.mag == '0) || (an_q.mag == '0);
      end
      SEL_B: begin
        red_x    = DW'(bn_q.mag);
        red_y    = DW'(bd_q.mag);
        red_skip = (bd_q.mag == '0) || (bn_q.mag == '0);
      end
      default: begin
        red_x    = n_q.mag;
        red_y    = d_q.mag;
        red_skip = (n_q.mag == '0);
      end
    endcase
  end

  // Restoring division step, run on both quotients against the same gcd.
  always_comb begin
    rx_sh = {rx_q, qx_q[DW-1]};
    ry_sh = {ry_q, qy_q[DW-1]};
    x_ge  = (rx_sh >= {1'b0, g_q});
    y_ge  = (ry_sh >= {1'b0, g_q});
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (op_valid_i) begin
          state_d = ST_RED;
        end
      end
      ST_RED: begin
        if (!red_skip) begin
          state_d = ST_GCD;
        end else if (sel_q == SEL_B) begin
          state_d = ST_M0;
        end else if (sel_q == SEL_R) begin
          state_d = ST_OUT;
        end
      end
      ST_GCD: begin
        if ((u_q == '0) || (v_q == '0)) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_q == CntW'(DW - 1)) begin
          state_d = ST_WB;
        end
      end
      ST_WB: begin
        unique case (sel_q)
          SEL_A:   state_d = ST_RED;
          SEL_B:   state_d = ST_M0;
          default: state_d = ST_OUT;
        endcase
      end
      ST_M0: state_d = ST_M1;
      ST_M1: state_d = ST_M2;
      ST_M2: state_d = finite_ops ? ST_M3 : ST_OUT;
      ST_M3: state_d = ST_RED;
      ST_OUT: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sel_q   <= SEL_A;
    end else begin
      state_q <= state_d;
      if (state_q == ST_IDLE) begin
        sel_q <= SEL_A;
      end else if ((state_q == ST_RED && red_skip && sel_q == SEL_A) ||
                   (state_q == ST_WB && sel_q == SEL_A)) begin
        sel_q <= SEL_B;
      end else if (state_q == ST_M3) begin
        sel_q <= SEL_R;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    unique case (state_q)
      ST_IDLE: begin
        kind_q <= op_i.kind;
        an_q   <= '{neg: op_i.a_num.neg, mag: op_i.a_num.mag[WIDTH-1:0]};
        ad_q   <= '{neg: op_i.a_den.neg, mag: op_i.a_den.mag[WIDTH-1:0]};
        bn_q   <= '{neg: op_i.b_num.neg, mag: op_i.b_num.mag[WIDTH-1:0]};
        bd_q   <= '{neg: op_i.b_den.neg, mag: op_i.b_den.mag[WIDTH-1:0]};
      end
      ST_RED: begin
        u_q  <= red_x;
        v_q  <= red_y;
        qx_q <= red_x;
        qy_q <= red_y;
        k_q  <= '0;
        // A zero numerator of a finite fraction forces the denominator to +1.
        if (red_skip) begin
          if (sel_q == SEL_A && ad_q.mag != '0) begin
            ad_q <= '{neg: 1'b0, mag: WIDTH'(1)};
          end else if (sel_q == SEL_B && bd_q.mag != '0) begin
            bd_q <= '{neg: 1'b0, mag: WIDTH'(1)};
          end else if (sel_q == SEL_R) begin
            n_q.neg <= 1'b0;
            d_q     <= '{neg: 1'b0, mag: DW'(1)};
          end
        end
      end
      ST_GCD: begin
        rx_q  <= '0;
        ry_q  <= '0;
        cnt_q <= '0;
        g_q   <= (u_q | v_q) << k_q;
        if (!u_q[0] && !v_q[0]) begin
          u_q <= u_q >> 1;
          v_q <= v_q >> 1;
          k_q <= k_q + 1'b1;
        end else if (!u_q[0]) begin
          u_q <= u_q >> 1;
        end else if (!v_q[0]) begin
          v_q <= v_q >> 1;
        end else if (u_q >= v_q) begin
          u_q <= u_q - v_q;
        end else begin
          v_q <= v_q - u_q;
        end
      end
      ST_DIV: begin
        rx_q  <= x_ge ? DW'(rx_sh - {1'b0, g_q}) : rx_sh[DW-1:0];
        ry_q  <= y_ge ? DW'(ry_sh - {1'b0, g_q}) : ry_sh[DW-1:0];
        qx_q  <= {qx_q[DW-2:0], x_ge};
        qy_q  <= {qy_q[DW-2:0], y_ge};
        cnt_q <= cnt_q + 1'b1;
      end
      ST_WB: begin
        unique case (sel_q)
          SEL_A: begin
            an_q.mag <= qx_q[WIDTH-1:0];
            ad_q.mag <= qy_q[WIDTH-1:0];
          end
          SEL_B: begin
            bn_q.mag <= qx_q[WIDTH-1:0];
            bd_q.mag <= qy_q[WIDTH-1:0];
          end
          default: begin
            n_q.mag <= qx_q;
            d_q.mag <= qy_q;
          end
        endcase
      end
      ST_M1: begin
        t_q <= prod_q;
      end
      ST_M2: begin
        if (finite_ops) begin
          n_q <= n_fin;
        end else begin
          n_q <= n_inf;
          d_q <= '0;
        end
      end
      ST_M3: begin
        d_q <= prod_q;
      end
      default: begin
      end
    endcase
  end

  assign op_ready_o  = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_OUT);

  always_comb begin
    res_o.num = trunc_out(n_q);
    res_o.den = trunc_out(d_q);
    if (res_o.den != '0) begin
      res_o.cls = rau_pkg::CLASS_FINITE;
    end else if (res_o.num != '0) begin
      res_o.cls = rau_pkg::CLASS_INF;
    end else begin
      res_o.cls = rau_pkg::CLASS_NAN;
    end
  end

endmodule

// ===== bench/rau_checker.sv =====
module rau_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  logic        full,
  input  logic [1:0]  kind_i,
  input  logic [31:0] a_num_i,
  input  logic [31:0] a_den_i,
  input  logic [31:0] b_num_i,
  input  logic [31:0] b_den_i,
  input  logic        empty,
  input  logic        pop,
  input  logic [31:0] res_num_i,
  input  logic [31:0] res_den_i,
  input  logic [1:0]  res_class_i,
  output int          errors_o,
  output int          outstanding_o
);

  typedef struct {
    bit        neg;
    bit [63:0] mag;
  } signed_mag_t;

  rau_pkg::res_t expected_fracs[$];
  int            errors;

  assign errors_o      = errors;
  assign outstanding_o = expected_fracs.size();

  function automatic bit [63:0] gcd64(input bit [63:0] x, input bit [63:0] y);
    bit [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic bit [63:0] abs64(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // A finite operand is divided by its positive gcd; zero over a nonzero value is 0/1.
  function automatic void reduce_operand(inout longint n, inout longint d);
    longint g;
    if (d == 0) return;
    if (n == 0) begin
      d = 1;
      return;
    end
    g = longint'(gcd64(abs64(n), abs64(d)));
    n = n / g;
    d = d / g;
  endfunction

  function automatic signed_mag_t times(input longint x, input longint y);
    signed_mag_t r;
    r.mag = abs64(x) * abs64(y);
    r.neg = ((x < 0) != (y < 0)) && (r.mag != 0);
    return r;
  endfunction

  function automatic signed_mag_t plus(input signed_mag_t p, input signed_mag_t q);
    signed_mag_t r;
    if (p.neg == q.neg) begin
      r.neg = p.neg;
      r.mag = p.mag + q.mag;
    end else if (p.mag >= q.mag) begin
      r.neg = p.neg;
      r.mag = p.mag - q.mag;
    end else begin
      r.neg = q.neg;
      r.mag = q.mag - p.mag;
    end
    if (r.mag == 0) r.neg = 1'b0;
    return r;
  endfunction

  function automatic bit [31:0] to_field(input signed_mag_t v);
    bit [63:0] u;
    u = v.neg ? -v.mag : v.mag;
    return u[31:0];
  endfunction

  function automatic rau_pkg::res_t fraction_result(input rau_pkg::kind_e op,
                                                    input logic [31:0] an_r,
                                                    input logic [31:0] ad_r,
                                                    input logic [31:0] bn_r,
                                                    input logic [31:0] bd_r);
    longint        an, ad, bn, bd, v;
    signed_mag_t   n, d, q;
    bit [63:0]     g;
    rau_pkg::res_t r;
    an = longint'($signed(an_r));
    ad = longint'($signed(ad_r));
    bn = longint'($signed(bn_r));
    bd = longint'($signed(bd_r));
    reduce_operand(an, ad);
    reduce_operand(bn, bd);
    if (ad == 0 || bd == 0) begin
      if (op == rau_pkg::KIND_ADD || op == rau_pkg::KIND_SUB) begin
        if ((an == 0 && ad == 0) || (bn == 0 && bd == 0)) v = 0;
        else v = (op == rau_pkg::KIND_ADD) ? an + bn : an - bn;
      end else if (op == rau_pkg::KIND_MUL) begin
        v = an * bn;
      end else begin
        v = an * bd;
      end
      r.num = v[31:0];
      r.den = '0;
    end else begin
      if (op == rau_pkg::KIND_ADD || op == rau_pkg::KIND_SUB) begin
        q = times(bn, ad);
        if (op == rau_pkg::KIND_SUB && q.mag != 0) q.neg = !q.neg;
        n = plus(times(an, bd), q);
        d = times(ad, bd);
      end else if (op == rau_pkg::KIND_MUL) begin
        n = times(an, bn);
        d = times(ad, bd);
      end else begin
        n = times(an, bd);
        d = times(ad, bn);
      end
      if (n.mag == 0) begin
        n.neg = 1'b0;
        d.neg = 1'b0;
        d.mag = 1;
      end else begin
        g = gcd64(n.mag, d.mag);
        n.mag = n.mag / g;
        d.mag = d.mag / g;
      end
      r.num = to_field(n);
      r.den = to_field(d);
    end
    r.cls = (r.den != 0) ? rau_pkg::CLASS_FINITE :
            ((r.num != 0) ? rau_pkg::CLASS_INF : rau_pkg::CLASS_NAN);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rau_pkg::res_t exp_r;
    if (!rst_ni) begin
      expected_fracs.delete();
      errors <= 0;
    end else begin
      if (push && !full)
        expected_fracs.push_back(fraction_result(rau_pkg::kind_e'(kind_i), a_num_i,
                                                 a_den_i, b_num_i, b_den_i));
      if (pop && !empty) begin
        if (expected_fracs.size() == 0) begin
          $display("%0t: result beat with nothing expected: %h/%h class %0d", $time,
                   res_num_i, res_den_i, res_class_i);
          errors <= errors + 1;
        end else begin
          exp_r = expected_fracs.pop_front();
          if (res_num_i !== exp_r.num || res_den_i !== exp_r.den ||
              res_class_i !== exp_r.cls) begin
            $display("%0t: mismatch expected %h/%h class %0d, actual %h/%h class %0d",
                     $time, exp_r.num, exp_r.den, exp_r.cls, res_num_i, res_den_i,
                     res_class_i);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

// ===== bench/tb_rational_arith_unit.sv =====
module tb_rational_arith_unit;

  localparam int NumRandom = 1700;
  localparam int DrainCycles = 700;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [1:0]  kind_i;
  logic [31:0] a_num_i, a_den_i, b_num_i, b_den_i;
  logic        empty;
  logic        pop;
  logic [31:0] res_num_o, res_den_o;
  logic [1:0]  res_class_o;
  int          errors;
  int          outstanding;
  int          burst_left;
  int          stall_mode;
  int          stall_cnt;

  rational_arith_unit uut (
    .clk_i, .rst_ni, .push, .full, .kind_i, .a_num_i, .a_den_i, .b_num_i, .b_den_i,
    .empty, .pop, .res_num_o, .res_den_o, .res_class_o
  );

  rau_checker u_checker (
    .clk_i, .rst_ni, .push, .full, .kind_i, .a_num_i, .a_den_i, .b_num_i, .b_den_i,
    .empty, .pop, .res_num_i(res_num_o), .res_den_i(res_den_o),
    .res_class_i(res_class_o), .errors_o(errors), .outstanding_o(outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #80_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // The receiver switches at random between several stall patterns.
  always @(posedge clk_i) begin
    if (stall_cnt == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_cnt  <= $urandom_range(50, 400);
    end else begin
      stall_cnt <= stall_cnt - 1;
    end
    case (stall_mode)
      0: pop <= 1'b1;
      1: pop <= ($urandom_range(0, 1) == 0);
      2: pop <= ($urandom_range(0, 7) == 0);
      default: pop <= (stall_cnt % 16) < 3;
    endcase
  end

  function automatic logic [31:0] rand_value(input bit is_den);
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: v = is_den ? 32'd0 : 32'd0;
      1: v = 32'h8000_0000;
      2: v = 32'h7fff_ffff;
      3: v = $urandom_range(0, 1) ? 32'd1 : 32'hffff_ffff;
      4, 5: v = $urandom;
      default: begin
        v = $urandom_range(1, 60) * (1 << $urandom_range(0, 4));
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  // Holds one beat on the channel until it is taken; push stays high inside a burst.
  task automatic send(input rau_pkg::kind_e op, input logic [31:0] an,
                      input logic [31:0] ad, input logic [31:0] bn,
                      input logic [31:0] bd);
    push    <= 1'b1;
    kind_i  <= op;
    a_num_i <= an;
    a_den_i <= ad;
    b_num_i <= bn;
    b_den_i <= bd;
    do @(posedge clk_i); while (full);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      push <= 1'b0;
      repeat ($urandom_range(0, 1) ? 0 : $urandom_range(1, 30)) @(posedge clk_i);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  initial begin
    logic [31:0] ext [5];
    ext = '{32'd0, 32'd1, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000};
    rst_ni     = 1'b0;
    push       = 1'b0;
    pop        = 1'b0;
    kind_i     = rau_pkg::KIND_ADD;
    a_num_i    = '0;
    a_den_i    = '0;
    b_num_i    = '0;
    b_den_i    = '0;
    burst_left = 0;
    stall_mode = 0;
    stall_cnt  = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Plain values under every operation, then the corner cases.
    for (int k = 0; k < 4; k++)
      send(rau_pkg::kind_e'(k), 32'd6, 32'd4, -32'd3, 32'd9);
    send(rau_pkg::KIND_ADD, 32'd0, 32'd0, 32'd5, 32'd1);
    send(rau_pkg::KIND_SUB, 32'd3, 32'd0, 32'd5, 32'd2);
    send(rau_pkg::KIND_MUL, 32'd0, 32'd0, 32'd0, 32'd0);
    send(rau_pkg::KIND_DIV, 32'd7, 32'd0, 32'd2, 32'd3);
    send(rau_pkg::KIND_DIV, 32'd0, 32'd5, 32'd0, 32'd3);
    send(rau_pkg::KIND_DIV, 32'd4, 32'd5, 32'd0, 32'd3);
    send(rau_pkg::KIND_MUL, 32'd0, -32'd7, 32'd5, -32'd3);
    send(rau_pkg::KIND_ADD, 32'd1, -32'd2, 32'd1, 32'd2);
    for (int i = 0; i < 5; i++)
      send(rau_pkg::kind_e'(i % 4), ext[i], ext[(i + 3) % 5], ext[(i + 1) % 5],
           ext[(i + 4) % 5]);
    send(rau_pkg::KIND_MUL, 32'h8000_0000, 32'd1, 32'h8000_0000, 32'd1);
    send(rau_pkg::KIND_ADD, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 32'd1);
    send(rau_pkg::KIND_DIV, 32'h8000_0000, 32'h7fff_ffff, 32'd1, 32'h8000_0000);

    for (int i = 0; i < NumRandom; i++) begin
      if (i == NumRandom / 2) begin
        push <= 1'b0;
        @(posedge clk_i);
        while (outstanding != 0) @(posedge clk_i);
      end
      send(rau_pkg::kind_e'($urandom_range(0, 3)), rand_value(0), rand_value(1),
           rand_value(0), rand_value(1));
    end
    push <= 1'b0;
    while (outstanding != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule
